>>> rtl/core/rti_pkg.sv
// Shared types and constants for the ray / triangle intersection pipeline.
// No dependencies.
`default_nettype none

package rti_pkg;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = 33;
    localparam int PROD_W  = 66;
    localparam int CROSS_W = 67;
    localparam int DOT_W   = 103;
    localparam int MAG_W   = 102;
    localparam int EPS_W   = 17;
    localparam int TQ_W    = 63;

    localparam logic [2:0] REG_ORG_X = 3'd0;
    localparam logic [2:0] REG_ORG_Y = 3'd1;
    localparam logic [2:0] REG_ORG_Z = 3'd2;
    localparam logic [2:0] REG_DIR_X = 3'd3;
    localparam logic [2:0] REG_DIR_Y = 3'd4;
    localparam logic [2:0] REG_DIR_Z = 3'd5;
    localparam logic [2:0] REG_EPS   = 3'd6;

    typedef enum logic [1:0] {
        MISS_NONE     = 2'd0,
        MISS_PARALLEL = 2'd1,
        MISS_BARY     = 2'd2,
        MISS_BEHIND   = 2'd3
    } miss_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] org_x;
        logic signed [COORD_W-1:0] org_y;
        logic signed [COORD_W-1:0] org_z;
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic signed [COORD_W-1:0] dir_z;
        logic [EPS_W-1:0]          eps;
    } ray_cfg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] vert_a_x;
        logic signed [COORD_W-1:0] vert_a_y;
        logic signed [COORD_W-1:0] vert_a_z;
        logic signed [COORD_W-1:0] vert_b_x;
        logic signed [COORD_W-1:0] vert_b_y;
        logic signed [COORD_W-1:0] vert_b_z;
        logic signed [COORD_W-1:0] vert_c_x;
        logic signed [COORD_W-1:0] vert_c_y;
        logic signed [COORD_W-1:0] vert_c_z;
    } tri_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] x;
        logic signed [DIFF_W-1:0] y;
        logic signed [DIFF_W-1:0] z;
    } dvec_t;

    typedef struct packed {
        logic signed [DOT_W-1:0] det;
        logic signed [DOT_W-1:0] nu;
        logic signed [DOT_W-1:0] nv;
        logic signed [DOT_W-1:0] nt;
    } geom_t;

    typedef struct packed {
        miss_t                   reason;
        logic [MAG_W-1:0]        m;
        logic signed [DOT_W-1:0] nt;
    } cls_t;

    typedef struct packed {
        miss_t           reason;
        logic [TQ_W-1:0] tq;
    } div_t;

    typedef struct packed {
        miss_t                     reason;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } res_t;

endpackage

`default_nettype wire

>>> rtl/core/rti_tri_if.sv
// Triangle input channel: valid/ready plus the nine vertex coordinates.
// No dependencies.
`default_nettype none

interface rti_tri_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vert_a_x;
    logic signed [31:0] vert_a_y;
    logic signed [31:0] vert_a_z;
    logic signed [31:0] vert_b_x;
    logic signed [31:0] vert_b_y;
    logic signed [31:0] vert_b_z;
    logic signed [31:0] vert_c_x;
    logic signed [31:0] vert_c_y;
    logic signed [31:0] vert_c_z;

    modport source(output valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y,
                   vert_b_z, vert_c_x, vert_c_y, vert_c_z, input ready);
    modport sink(input valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y,
                 vert_b_z, vert_c_x, vert_c_y, vert_c_z, output ready);
endinterface

`default_nettype wire

>>> rtl/core/rti_res_if.sv
// Result channel: valid/ready plus hit flag, miss reason and hit point.
// No dependencies.
`default_nettype none

interface rti_res_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic [1:0]         miss_reason;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;

    modport source(output valid, hit, miss_reason, point_x, point_y, point_z,
                   input ready);
    modport sink(input valid, hit, miss_reason, point_x, point_y, point_z,
                 output ready);
endinterface

`default_nettype wire

>>> rtl/core/rti_geom.sv
// Edge vectors, cross products and the four dot products (det, nu, nv, nt).
// Six stages. Depends on rti_pkg.
`default_nettype none

module rti_geom (
    input  logic             clk,
    input  logic             rst_n,
    input  rti_pkg::ray_cfg_t cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  rti_pkg::tri_t    in_tri,
    output logic             out_valid,
    input  logic             out_ready,
    output rti_pkg::geom_t   out_geom
);
    import rti_pkg::*;

    localparam int NS = 6;

    function automatic logic signed [DIFF_W-1:0] comp(dvec_t v, int j);
        logic signed [DIFF_W-1:0] r;
        case (j)
            0:       r = v.x;
            1:       r = v.y;
            default: r = v.z;
        endcase
        return r;
    endfunction

    logic [NS-1:0] v_reg;
    logic [NS:0]   en;

    assign en[NS] = out_ready;
    generate
        for (genvar i = 0; i < NS; i++)
        begin : g_en
            assign en[i] = !v_reg[i] || en[i+1];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid;
            for (int i = 1; i < NS; i++)
                if (en[i])
                    v_reg[i] <= v_reg[i-1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];

    dvec_t d;
    always_comb
    begin
        d.x = DIFF_W'(cfg.dir_x);
        d.y = DIFF_W'(cfg.dir_y);
        d.z = DIFF_W'(cfg.dir_z);
    end

    // stage 1: edges
    dvec_t e1_s1_reg, e2_s1_reg, s_s1_reg;
    dvec_t e1_s1_next, e2_s1_next, s_s1_next;
    always_comb
    begin
        e1_s1_next.x = DIFF_W'(in_tri.vert_b_x) - DIFF_W'(in_tri.vert_a_x);
        e1_s1_next.y = DIFF_W'(in_tri.vert_b_y) - DIFF_W'(in_tri.vert_a_y);
        e1_s1_next.z = DIFF_W'(in_tri.vert_b_z) - DIFF_W'(in_tri.vert_a_z);
        e2_s1_next.x = DIFF_W'(in_tri.vert_c_x) - DIFF_W'(in_tri.vert_a_x);
        e2_s1_next.y = DIFF_W'(in_tri.vert_c_y) - DIFF_W'(in_tri.vert_a_y);
        e2_s1_next.z = DIFF_W'(in_tri.vert_c_z) - DIFF_W'(in_tri.vert_a_z);
        s_s1_next.x  = DIFF_W'(cfg.org_x) - DIFF_W'(in_tri.vert_a_x);
        s_s1_next.y  = DIFF_W'(cfg.org_y) - DIFF_W'(in_tri.vert_a_y);
        s_s1_next.z  = DIFF_W'(cfg.org_z) - DIFF_W'(in_tri.vert_a_z);
    end

    // stage 2: cross product terms, p = d x e2, q = s x e1
    logic signed [PROD_W-1:0] cp_reg [12];
    logic signed [PROD_W-1:0] cp_next [12];
    dvec_t e1_s2_reg, e2_s2_reg, s_s2_reg;
    always_comb
    begin
        cp_next[0]  = d.y * e2_s1_reg.z;
        cp_next[1]  = d.z * e2_s1_reg.y;
        cp_next[2]  = d.z * e2_s1_reg.x;
        cp_next[3]  = d.x * e2_s1_reg.z;
        cp_next[4]  = d.x * e2_s1_reg.y;
        cp_next[5]  = d.y * e2_s1_reg.x;
        cp_next[6]  = s_s1_reg.y * e1_s1_reg.z;
        cp_next[7]  = s_s1_reg.z * e1_s1_reg.y;
        cp_next[8]  = s_s1_reg.z * e1_s1_reg.x;
        cp_next[9]  = s_s1_reg.x * e1_s1_reg.z;
        cp_next[10] = s_s1_reg.x * e1_s1_reg.y;
        cp_next[11] = s_s1_reg.y * e1_s1_reg.x;
    end

    // stage 3: p and q
    logic signed [CROSS_W-1:0] pq_reg [6];
    logic signed [CROSS_W-1:0] pq_next [6];
    dvec_t e1_s3_reg, e2_s3_reg, s_s3_reg;
    always_comb
    begin
        for (int k = 0; k < 6; k++)
            pq_next[k] = CROSS_W'(cp_reg[2*k]) - CROSS_W'(cp_reg[2*k+1]);
    end

    // stage 4: dot product partial products, b split at bit 34
    logic signed [DIFF_W-1:0]  a_op [12];
    logic signed [CROSS_W-1:0] b_op [12];
    logic signed [67:0]        lo_reg [12];
    logic signed [67:0]        lo_next [12];
    logic signed [65:0]        hi_reg [12];
    logic signed [65:0]        hi_next [12];
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            a_op[j]     = comp(e1_s3_reg, j);
            b_op[j]     = pq_reg[j];
            a_op[3+j]   = comp(s_s3_reg, j);
            b_op[3+j]   = pq_reg[j];
            a_op[6+j]   = comp(d, j);
            b_op[6+j]   = pq_reg[3+j];
            a_op[9+j]   = comp(e2_s3_reg, j);
            b_op[9+j]   = pq_reg[3+j];
        end
        for (int k = 0; k < 12; k++)
        begin
            lo_next[k] = a_op[k] * $signed({1'b0, b_op[k][33:0]});
            hi_next[k] = a_op[k] * $signed(b_op[k][66:34]);
        end
    end

    // stage 5: full products
    logic signed [DOT_W-1:0] pr_reg [12];
    logic signed [DOT_W-1:0] pr_next [12];
    always_comb
    begin
        for (int k = 0; k < 12; k++)
            pr_next[k] = (DOT_W'(hi_reg[k]) <<< 34) + DOT_W'(lo_reg[k]);
    end

    // stage 6: sums
    geom_t geom_reg, geom_next;
    always_comb
    begin
        geom_next.det = pr_reg[0] + pr_reg[1] + pr_reg[2];
        geom_next.nu  = pr_reg[3] + pr_reg[4] + pr_reg[5];
        geom_next.nv  = pr_reg[6] + pr_reg[7] + pr_reg[8];
        geom_next.nt  = pr_reg[9] + pr_reg[10] + pr_reg[11];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            e1_s1_reg <= e1_s1_next;
            e2_s1_reg <= e2_s1_next;
            s_s1_reg  <= s_s1_next;
        end
        if (en[1])
        begin
            cp_reg    <= cp_next;
            e1_s2_reg <= e1_s1_reg;
            e2_s2_reg <= e2_s1_reg;
            s_s2_reg  <= s_s1_reg;
        end
        if (en[2])
        begin
            pq_reg    <= pq_next;
            e1_s3_reg <= e1_s2_reg;
            e2_s3_reg <= e2_s2_reg;
            s_s3_reg  <= s_s2_reg;
        end
        if (en[3])
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
        if (en[4])
            pr_reg <= pr_next;
        if (en[5])
            geom_reg <= geom_next;
    end

    assign out_geom = geom_reg;

endmodule

`default_nettype wire

>>> rtl/core/rti_classify.sv
// Sign normalisation and the parallel, barycentric and ray-behind tests.
// Three stages. Depends on rti_pkg.
`default_nettype none

module rti_classify #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rti_pkg::ray_cfg_t cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  rti_pkg::geom_t    in_geom,
    output logic              out_valid,
    input  logic              out_ready,
    output rti_pkg::cls_t     out_cls
);
    import rti_pkg::*;

    localparam int NS   = 3;
    localparam int EP_W = EPS_W + 34;
    localparam int EM_W = EPS_W + MAG_W;
    localparam int CW   = DOT_W + FRAC_BITS + EPS_W + 1;

    logic [NS-1:0] v_reg;
    logic [NS:0]   en;

    assign en[NS] = out_ready;
    generate
        for (genvar i = 0; i < NS; i++)
        begin : g_en
            assign en[i] = !v_reg[i] || en[i+1];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid;
            for (int i = 1; i < NS; i++)
                if (en[i])
                    v_reg[i] <= v_reg[i-1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];

    // stage 1: make det non-negative
    geom_t n_reg, n_next;
    always_comb
    begin
        if (in_geom.det[DOT_W-1])
        begin
            n_next.det = -in_geom.det;
            n_next.nu  = -in_geom.nu;
            n_next.nv  = -in_geom.nv;
            n_next.nt  = -in_geom.nt;
        end
        else
        begin
            n_next = in_geom;
        end
    end

    // stage 2: range tests, eps * m partial products
    logic                    par_reg, par_next;
    logic                    bary_reg, bary_next;
    logic [EP_W-1:0]         ep_reg [3];
    logic [EP_W-1:0]         ep_next [3];
    logic [MAG_W-1:0]        m_reg;
    logic signed [DOT_W-1:0] nt_reg;
    logic signed [DOT_W:0]   uv_sum;
    logic [DOT_W-1:0]        eps_sh;
    always_comb
    begin
        eps_sh    = DOT_W'(cfg.eps) << (2 * FRAC_BITS);
        par_next  = (n_reg.det == '0) || ($unsigned(n_reg.det) < eps_sh);
        uv_sum    = (DOT_W+1)'(n_reg.nu) + (DOT_W+1)'(n_reg.nv);
        bary_next = n_reg.nu[DOT_W-1] || (n_reg.nu > n_reg.det) ||
                    n_reg.nv[DOT_W-1] || (uv_sum > (DOT_W+1)'(n_reg.det));
        for (int j = 0; j < 3; j++)
            ep_next[j] = cfg.eps * n_reg.det[34*j +: 34];
    end

    // stage 3: t beyond epsilon, reason
    cls_t                  cls_reg, cls_next;
    logic [EM_W-1:0]       em;
    logic signed [CW-1:0]  lhs;
    logic signed [CW-1:0]  rhs;
    always_comb
    begin
        em  = EM_W'(ep_reg[0]) + (EM_W'(ep_reg[1]) << 34) + (EM_W'(ep_reg[2]) << 68);
        lhs = $signed(CW'(em));
        rhs = CW'(nt_reg) <<< FRAC_BITS;
        if (par_reg)
            cls_next.reason = MISS_PARALLEL;
        else if (bary_reg)
            cls_next.reason = MISS_BARY;
        else if (!(lhs < rhs))
            cls_next.reason = MISS_BEHIND;
        else
            cls_next.reason = MISS_NONE;
        cls_next.m  = m_reg;
        cls_next.nt = nt_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
            n_reg <= n_next;
        if (en[1])
        begin
            par_reg  <= par_next;
            bary_reg <= bary_next;
            ep_reg   <= ep_next;
            m_reg    <= n_reg.det[MAG_W-1:0];
            nt_reg   <= n_reg.nt;
        end
        if (en[2])
            cls_reg <= cls_next;
    end

    assign out_cls = cls_reg;

endmodule

`default_nettype wire

>>> rtl/core/rti_div.sv
// Restoring divider for tq = floor(nt * 2^F / m), one quotient bit a stage,
// saturated to 2^63-1. Depends on rti_pkg.
`default_nettype none

module rti_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  rti_pkg::cls_t in_cls,
    output logic          out_valid,
    input  logic          out_ready,
    output rti_pkg::div_t out_div
);
    import rti_pkg::*;

    localparam int NS = TQ_W + 1;
    localparam int RW = MAG_W + TQ_W + 1;

    logic [NS-1:0] v_reg;
    logic [NS:0]   en;

    assign en[NS] = out_ready;
    generate
        for (genvar i = 0; i < NS; i++)
        begin : g_en
            assign en[i] = !v_reg[i] || en[i+1];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid;
            for (int i = 1; i < NS; i++)
                if (en[i])
                    v_reg[i] <= v_reg[i-1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];

    logic [RW-1:0]    rem_reg [NS];
    logic [RW-1:0]    rem_next [NS];
    logic [TQ_W-1:0]  q_reg [NS];
    logic [TQ_W-1:0]  q_next [NS];
    logic [MAG_W-1:0] m_reg [NS];
    logic             sat_reg [NS];
    logic             sat_next;
    miss_t            reason_reg [NS];
    logic [RW-1:0]    dsh [NS];
    logic             ge [NS];

    always_comb
    begin
        rem_next[0] = RW'($unsigned(in_cls.nt)) << FRAC_BITS;
        q_next[0]   = '0;
        dsh[0]      = RW'(in_cls.m) << TQ_W;
        ge[0]       = rem_next[0] >= dsh[0];
        sat_next    = ge[0];
        for (int k = 1; k < NS; k++)
        begin
            dsh[k]      = RW'(m_reg[k-1]) << (TQ_W - k);
            ge[k]       = rem_reg[k-1] >= dsh[k];
            rem_next[k] = ge[k] ? rem_reg[k-1] - dsh[k] : rem_reg[k-1];
            q_next[k]   = q_reg[k-1] | (TQ_W'(ge[k]) << (TQ_W - k));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0]    <= rem_next[0];
            q_reg[0]      <= q_next[0];
            m_reg[0]      <= in_cls.m;
            sat_reg[0]    <= sat_next;
            reason_reg[0] <= in_cls.reason;
        end
        for (int k = 1; k < NS; k++)
        begin
            if (en[k])
            begin
                rem_reg[k]    <= rem_next[k];
                q_reg[k]      <= q_next[k];
                m_reg[k]      <= m_reg[k-1];
                sat_reg[k]    <= sat_reg[k-1];
                reason_reg[k] <= reason_reg[k-1];
            end
        end
    end

    assign out_div.reason = reason_reg[NS-1];
    assign out_div.tq     = sat_reg[NS-1] ? {TQ_W{1'b1}} : q_reg[NS-1];

endmodule

`default_nettype wire

>>> rtl/core/rti_trace.sv
// Hit point origin + dir * tq / 2^F with 32-bit saturation, zero on a miss.
// Three stages. Depends on rti_pkg.
`default_nettype none

module rti_trace #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rti_pkg::ray_cfg_t cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  rti_pkg::div_t     in_div,
    output logic              out_valid,
    input  logic              out_ready,
    output rti_pkg::res_t     out_res
);
    import rti_pkg::*;

    localparam int NS = 3;
    localparam int PW = 97;

    logic [NS-1:0] v_reg;
    logic [NS:0]   en;

    assign en[NS] = out_ready;
    generate
        for (genvar i = 0; i < NS; i++)
        begin : g_en
            assign en[i] = !v_reg[i] || en[i+1];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid;
            for (int i = 1; i < NS; i++)
                if (en[i])
                    v_reg[i] <= v_reg[i-1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];

    logic signed [COORD_W-1:0] dir_a [3];
    logic signed [COORD_W-1:0] org_a [3];
    always_comb
    begin
        dir_a[0] = cfg.dir_x;
        dir_a[1] = cfg.dir_y;
        dir_a[2] = cfg.dir_z;
        org_a[0] = cfg.org_x;
        org_a[1] = cfg.org_y;
        org_a[2] = cfg.org_z;
    end

    // stage 1: partial products, tq split at bit 32
    logic signed [64:0] pl_reg [3];
    logic signed [64:0] pl_next [3];
    logic signed [63:0] ph_reg [3];
    logic signed [63:0] ph_next [3];
    miss_t              r1_reg, r2_reg;
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            pl_next[j] = dir_a[j] * $signed({1'b0, in_div.tq[31:0]});
            ph_next[j] = dir_a[j] * $signed({1'b0, in_div.tq[TQ_W-1:32]});
        end
    end

    // stage 2: product scaled back to FRAC_BITS
    logic signed [PW-1:0] sh_reg [3];
    logic signed [PW-1:0] sh_next [3];
    always_comb
    begin
        for (int j = 0; j < 3; j++)
            sh_next[j] = ((PW'(ph_reg[j]) <<< 32) + PW'(pl_reg[j])) >>> FRAC_BITS;
    end

    // stage 3: add origin and saturate
    logic signed [PW:0]        sum [3];
    logic signed [COORD_W-1:0] pt [3];
    res_t                      res_reg, res_next;
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            sum[j] = (PW+1)'(org_a[j]) + (PW+1)'(sh_reg[j]);
            if (r2_reg != MISS_NONE)
                pt[j] = '0;
            else if (sum[j][PW:COORD_W-1] == '0 || sum[j][PW:COORD_W-1] == '1)
                pt[j] = sum[j][COORD_W-1:0];
            else if (sum[j][PW])
                pt[j] = {1'b1, {(COORD_W-1){1'b0}}};
            else
                pt[j] = {1'b0, {(COORD_W-1){1'b1}}};
        end
        res_next.reason  = r2_reg;
        res_next.point_x = pt[0];
        res_next.point_y = pt[1];
        res_next.point_z = pt[2];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pl_reg <= pl_next;
            ph_reg <= ph_next;
            r1_reg <= in_div.reason;
        end
        if (en[1])
        begin
            sh_reg <= sh_next;
            r2_reg <= r1_reg;
        end
        if (en[2])
            res_reg <= res_next;
    end

    assign out_res = res_reg;

endmodule

`default_nettype wire

>>> rtl/core/ray_triangle_intersect.sv
// Ray / triangle intersection top level: APB ray registers and a 76-stage pipeline
// (geometry 6, tests 3, divider 64, hit point 3). Throughput one triangle word per
// cycle while the output is ready; the divider's one quotient bit per stage sets
// the depth. Each stage holds its word under back-pressure and takes a new one
// when it empties. Reset clears all valid bits and loads the register defaults.
`default_nettype none

module ray_triangle_intersect #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    rti_tri_if.sink     tri_in,
    rti_res_if.source   res_out
);
    import rti_pkg::*;

    ray_cfg_t   cfg_reg, cfg_next;
    logic [2:0] idx;
    logic       wr;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (idx)
                REG_ORG_X: cfg_next.org_x = pwdata;
                REG_ORG_Y: cfg_next.org_y = pwdata;
                REG_ORG_Z: cfg_next.org_z = pwdata;
                REG_DIR_X: cfg_next.dir_x = pwdata;
                REG_DIR_Y: cfg_next.dir_y = pwdata;
                REG_DIR_Z: cfg_next.dir_z = pwdata;
                REG_EPS:   cfg_next.eps   = pwdata[EPS_W-1:0];
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.org_x <= '0;
            cfg_reg.org_y <= '0;
            cfg_reg.org_z <= '0;
            cfg_reg.dir_x <= '0;
            cfg_reg.dir_y <= '0;
            cfg_reg.dir_z <= 32'sh0001_0000;
            cfg_reg.eps   <= 17'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_ORG_X: prdata = cfg_reg.org_x;
            REG_ORG_Y: prdata = cfg_reg.org_y;
            REG_ORG_Z: prdata = cfg_reg.org_z;
            REG_DIR_X: prdata = cfg_reg.dir_x;
            REG_DIR_Y: prdata = cfg_reg.dir_y;
            REG_DIR_Z: prdata = cfg_reg.dir_z;
            REG_EPS:   prdata = 32'(cfg_reg.eps);
            default:   prdata = '0;
        endcase
    end

    tri_t  tri_w;
    geom_t geom_w;
    cls_t  cls_w;
    div_t  div_w;
    res_t  res_w;
    logic  g_valid, g_ready, c_valid, c_ready, d_valid, d_ready;

    always_comb
    begin
        tri_w.vert_a_x = tri_in.vert_a_x;
        tri_w.vert_a_y = tri_in.vert_a_y;
        tri_w.vert_a_z = tri_in.vert_a_z;
        tri_w.vert_b_x = tri_in.vert_b_x;
        tri_w.vert_b_y = tri_in.vert_b_y;
        tri_w.vert_b_z = tri_in.vert_b_z;
        tri_w.vert_c_x = tri_in.vert_c_x;
        tri_w.vert_c_y = tri_in.vert_c_y;
        tri_w.vert_c_z = tri_in.vert_c_z;
    end

    rti_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (tri_in.valid),
        .in_ready  (tri_in.ready),
        .in_tri    (tri_w),
        .out_valid (g_valid),
        .out_ready (g_ready),
        .out_geom  (geom_w)
    );

    rti_classify #(.FRAC_BITS(FRAC_BITS)) u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (g_valid),
        .in_ready  (g_ready),
        .in_geom   (geom_w),
        .out_valid (c_valid),
        .out_ready (c_ready),
        .out_cls   (cls_w)
    );

    rti_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid),
        .in_ready  (c_ready),
        .in_cls    (cls_w),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_div   (div_w)
    );

    rti_trace #(.FRAC_BITS(FRAC_BITS)) u_trace (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (d_valid),
        .in_ready  (d_ready),
        .in_div    (div_w),
        .out_valid (res_out.valid),
        .out_ready (res_out.ready),
        .out_res   (res_w)
    );

    assign res_out.hit         = (res_w.reason == MISS_NONE);
    assign res_out.miss_reason = res_w.reason;
    assign res_out.point_x     = res_w.point_x;
    assign res_out.point_y     = res_w.point_y;
    assign res_out.point_z     = res_w.point_z;

endmodule

`default_nettype wire

>>> bench/ray_triangle_intersect_test.sv
// Testbench for ray_triangle_intersect: drives triangle words and APB ray registers,
// predicts each result in exact wide integer arithmetic and checks it in order.
// Depends on rti_pkg, rti_tri_if, rti_res_if and the ray_triangle_intersect RTL.
`default_nettype none

module ray_triangle_intersect_test;
    import rti_pkg::*;

    localparam int LATENCY  = 76;
    localparam int N_RANDOM = 920;

    typedef struct {
        logic                      hit;
        miss_t                     reason;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
    } hit_word_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rti_tri_if tri_ch();
    rti_res_if res_ch();

    ray_triangle_intersect dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .tri_in  (tri_ch),
        .res_out (res_ch)
    );

    logic signed [31:0] ray_org [3];
    logic signed [31:0] ray_dir [3];
    logic [EPS_W-1:0]   ray_eps;

    hit_word_t pending_hits[$];
    int        n_errors;
    int        burst_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("timeout at %0t", $time);
        $display("** ray_triangle_intersect: FAILED **");
        $finish;
    end

    function automatic logic signed [127:0] sat32(logic signed [127:0] v);
        if (v < -128'sd2147483648)
            return -128'sd2147483648;
        if (v > 128'sd2147483647)
            return 128'sd2147483647;
        return v;
    endfunction

    function automatic hit_word_t intersect_ray(tri_t t);
        logic signed [127:0] a [3];
        logic signed [127:0] b [3];
        logic signed [127:0] c [3];
        logic signed [127:0] o [3];
        logic signed [127:0] d [3];
        logic signed [127:0] e1 [3];
        logic signed [127:0] e2 [3];
        logic signed [127:0] s [3];
        logic signed [127:0] p [3];
        logic signed [127:0] q [3];
        logic signed [127:0] pt [3];
        logic signed [127:0] det, nu, nv, nt, eps, tq;
        hit_word_t r;
        a[0] = t.vert_a_x; a[1] = t.vert_a_y; a[2] = t.vert_a_z;
        b[0] = t.vert_b_x; b[1] = t.vert_b_y; b[2] = t.vert_b_z;
        c[0] = t.vert_c_x; c[1] = t.vert_c_y; c[2] = t.vert_c_z;
        for (int i = 0; i < 3; i++)
        begin
            o[i]  = ray_org[i];
            d[i]  = ray_dir[i];
            e1[i] = b[i] - a[i];
            e2[i] = c[i] - a[i];
            s[i]  = o[i] - a[i];
        end
        p[0] = d[1] * e2[2] - d[2] * e2[1];
        p[1] = d[2] * e2[0] - d[0] * e2[2];
        p[2] = d[0] * e2[1] - d[1] * e2[0];
        q[0] = s[1] * e1[2] - s[2] * e1[1];
        q[1] = s[2] * e1[0] - s[0] * e1[2];
        q[2] = s[0] * e1[1] - s[1] * e1[0];
        det = e1[0] * p[0] + e1[1] * p[1] + e1[2] * p[2];
        nu  = s[0] * p[0] + s[1] * p[1] + s[2] * p[2];
        nv  = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
        nt  = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
        eps = $signed({111'd0, ray_eps});
        if (det < 0)
        begin
            det = -det; nu = -nu; nv = -nv; nt = -nt;
        end
        if (det == 0 || det < (eps <<< 32))
            r.reason = MISS_PARALLEL;
        else if (nu < 0 || nu > det)
            r.reason = MISS_BARY;
        else if (nv < 0 || nu + nv > det)
            r.reason = MISS_BARY;
        else if (!(eps * det < (nt <<< 16)))
            r.reason = MISS_BEHIND;
        else
            r.reason = MISS_NONE;
        r.hit = (r.reason == MISS_NONE);
        r.px = '0; r.py = '0; r.pz = '0;
        if (r.hit)
        begin
            tq = (nt <<< 16) / det;
            if (tq > 128'sh7FFF_FFFF_FFFF_FFFF)
                tq = 128'sh7FFF_FFFF_FFFF_FFFF;
            for (int i = 0; i < 3; i++)
                pt[i] = sat32(o[i] + ((d[i] * tq) >>> 16));
            r.px = pt[0][31:0]; r.py = pt[1][31:0]; r.pz = pt[2][31:0];
        end
        return r;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(negedge clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = {idx, 2'b00}; pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            REG_ORG_X: ray_org[0] = value;
            REG_ORG_Y: ray_org[1] = value;
            REG_ORG_Z: ray_org[2] = value;
            REG_DIR_X: ray_dir[0] = value;
            REG_DIR_Y: ray_dir[1] = value;
            REG_DIR_Z: ray_dir[2] = value;
            REG_EPS:   ray_eps    = value[EPS_W-1:0];
            default: ;
        endcase
    endtask

    // let the pipeline drain before touching the ray
    task automatic drain;
        @(negedge clk);
        tri_ch.valid = 1'b0;
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic set_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                           logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                           logic [31:0] eps);
        drain();
        write_reg(REG_ORG_X, ox);
        write_reg(REG_ORG_Y, oy);
        write_reg(REG_ORG_Z, oz);
        write_reg(REG_DIR_X, dx);
        write_reg(REG_DIR_Y, dy);
        write_reg(REG_DIR_Z, dz);
        write_reg(REG_EPS, eps);
    endtask

    task automatic send_tri(tri_t t);
        if (burst_left == 0)
        begin
            @(negedge clk);
            tri_ch.valid = 1'b0;
            repeat ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 40);
        end
        else
            @(negedge clk);
        burst_left--;
        tri_ch.valid    = 1'b1;
        tri_ch.vert_a_x = t.vert_a_x; tri_ch.vert_a_y = t.vert_a_y;
        tri_ch.vert_a_z = t.vert_a_z; tri_ch.vert_b_x = t.vert_b_x;
        tri_ch.vert_b_y = t.vert_b_y; tri_ch.vert_b_z = t.vert_b_z;
        tri_ch.vert_c_x = t.vert_c_x; tri_ch.vert_c_y = t.vert_c_y;
        tri_ch.vert_c_z = t.vert_c_z;
        do @(posedge clk); while (!tri_ch.ready);
        pending_hits.push_back(intersect_ray(t));
    endtask

    function automatic tri_t make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                      int cx, int cy, int cz);
        tri_t t;
        t.vert_a_x = ax; t.vert_a_y = ay; t.vert_a_z = az;
        t.vert_b_x = bx; t.vert_b_y = by; t.vert_b_z = bz;
        t.vert_c_x = cx; t.vert_c_y = cy; t.vert_c_z = cz;
        return t;
    endfunction

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    // triangle scattered around a point on the ray, mostly in front of the origin
    function automatic tri_t aimed_tri(int span);
        logic [31:0] v [9];
        int          k;
        k = $urandom_range(0, 9) - 1;
        for (int i = 0; i < 9; i++)
            v[i] = ray_org[i % 3] + ray_dir[i % 3] * k
                 + $signed($urandom_range(0, 2 * span)) - span;
        return make_tri(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]);
    endfunction

    task automatic test_default_ray;
        int u;
        u = 32'h1_0000;
        send_tri(make_tri(-u, -u, 5 * u, u, -u, 5 * u, 0, u, 5 * u));
        send_tri(make_tri(-u, -u, 5 * u, 0, u, 5 * u, u, -u, 5 * u));
        send_tri(make_tri(u, -u, 5 * u, 3 * u, -u, 5 * u, 2 * u, u, 5 * u));
        send_tri(make_tri(-u, u, 5 * u, u, u, 5 * u, 0, 3 * u, 5 * u));
        send_tri(make_tri(-u, -u, -5 * u, u, -u, -5 * u, 0, u, -5 * u));
        send_tri(make_tri(-u, -u, 0, u, -u, 0, 0, u, 0));
        send_tri(make_tri(0, -u, 0, 0, u, 0, 0, 0, 5 * u));
        send_tri(make_tri(u, u, u, u, u, u, u, u, u));
        send_tri(make_tri(0, 0, 2 * u, u, 0, 2 * u, 0, u, 2 * u));
        send_tri(make_tri(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                          0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_tri(make_tri(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 32'h7FFF_FFFF, 32'h0));
        send_tri(make_tri(-1, -1, 1, 1, -1, 1, 0, 1, 1));
    endtask

    task automatic test_epsilon_limits;
        int u;
        u = 32'h1_0000;
        set_ray(0, 0, 0, 0, 0, u, 0);
        send_tri(make_tri(-1, -1, 1, 1, -1, 1, 0, 1, 1));
        send_tri(make_tri(-u, -u, 0, u, -u, 0, 0, u, 0));
        send_tri(make_tri(u, u, u, u, u, u, u, u, u));
        set_ray(0, 0, 0, 0, 0, u, 32'h1_0000);
        send_tri(make_tri(-u, -u, 5 * u, u, -u, 5 * u, 0, u, 5 * u));
        send_tri(make_tri(-u, -u, u / 2, u, -u, u / 2, 0, u, u / 2));
        send_tri(make_tri(-8 * u, -8 * u, 3 * u, 8 * u, -8 * u, 3 * u, 0, 8 * u, 3 * u));
    endtask

    task automatic test_point_saturation;
        int u;
        u = 32'h1_0000;
        set_ray(32'h7FFF_0000, 32'h8000_0000, 0,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1);
        send_tri(make_tri(32'h7FFF_FFFF, 32'h8000_0000, 32'h7000_0000,
                          32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_tri(make_tri(-u, -u, 4 * u, u, -u, 4 * u, 0, u, 4 * u));
        set_ray(0, 0, 0, 1, 0, 0, 1);
        send_tri(make_tri(32'h7FFF_FFFF, -u, -u, 32'h7FFF_FFFF, u, -u,
                          32'h7FFF_FFFF, 0, u));
    endtask

    task automatic test_random_triangles;
        tri_t t;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n % 115 == 0)
            begin
                if ($urandom_range(0, 3) == 0)
                    set_ray(pick_coord(), pick_coord(), pick_coord(),
                            pick_coord(), pick_coord(), pick_coord(),
                            $urandom_range(0, 1) ? 32'h1_0000 : $urandom_range(0, 65536));
                else
                    set_ray($urandom_range(0, 32'h00C8_0000) - 32'h0064_0000,
                            $urandom_range(0, 32'h00C8_0000) - 32'h0064_0000,
                            $urandom_range(0, 32'h00C8_0000) - 32'h0064_0000,
                            $urandom_range(0, 32'h0008_0000) - 32'h0004_0000,
                            $urandom_range(0, 32'h0008_0000) - 32'h0004_0000,
                            $urandom_range(0, 32'h0008_0000) - 32'h0004_0000,
                            $urandom_range(0, 4) == 0 ? 0 : $urandom_range(0, 64));
            end
            case ($urandom_range(0, 9))
                0, 1:
                    t = make_tri(pick_coord(), pick_coord(), pick_coord(),
                                 pick_coord(), pick_coord(), pick_coord(),
                                 pick_coord(), pick_coord(), pick_coord());
                2:
                    t = aimed_tri(32'h7FFF_FFFF);
                default:
                    t = aimed_tri($urandom_range(1, 32'h0040_0000));
            endcase
            send_tri(t);
        end
    endtask

    initial
    begin
        int stall_run;
        int stall_pct;
        res_ch.ready = 1'b0;
        stall_run = 0;
        stall_pct = 0;
        forever
        begin
            @(negedge clk);
            if (stall_run == 0)
            begin
                stall_run = $urandom_range(4, 60);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            stall_run--;
            res_ch.ready = ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        hit_word_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_hits.size() == 0)
            begin
                $display("%0t: unexpected word hit=%0b reason=%0d", $time,
                         res_ch.hit, res_ch.miss_reason);
                n_errors++;
            end
            else
            begin
                want = pending_hits.pop_front();
                if (res_ch.hit !== want.hit)
                begin
                    $display("%0t: hit expected %0b actual %0b", $time, want.hit,
                             res_ch.hit);
                    n_errors++;
                end
                if (res_ch.miss_reason !== want.reason)
                begin
                    $display("%0t: miss_reason expected %0d actual %0d", $time,
                             want.reason, res_ch.miss_reason);
                    n_errors++;
                end
                if (res_ch.point_x !== want.px)
                begin
                    $display("%0t: point_x expected %h actual %h", $time, want.px,
                             res_ch.point_x);
                    n_errors++;
                end
                if (res_ch.point_y !== want.py)
                begin
                    $display("%0t: point_y expected %h actual %h", $time, want.py,
                             res_ch.point_y);
                    n_errors++;
                end
                if (res_ch.point_z !== want.pz)
                begin
                    $display("%0t: point_z expected %h actual %h", $time, want.pz,
                             res_ch.point_z);
                    n_errors++;
                end
            end
        end
    end

    initial
    begin
        n_errors   = 0;
        burst_left = 0;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        tri_ch.valid = 1'b0;
        tri_ch.vert_a_x = '0; tri_ch.vert_a_y = '0; tri_ch.vert_a_z = '0;
        tri_ch.vert_b_x = '0; tri_ch.vert_b_y = '0; tri_ch.vert_b_z = '0;
        tri_ch.vert_c_x = '0; tri_ch.vert_c_y = '0; tri_ch.vert_c_z = '0;
        ray_org[0] = 0; ray_org[1] = 0; ray_org[2] = 0;
        ray_dir[0] = 0; ray_dir[1] = 0; ray_dir[2] = 32'h1_0000;
        ray_eps    = 1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_default_ray();
        test_epsilon_limits();
        test_point_saturation();
        test_random_triangles();

        drain();
        if (n_errors == 0)
            $display("** ray_triangle_intersect: PASSED **");
        else
            $display("** ray_triangle_intersect: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
rtl/core/rti_pkg.sv
rtl/core/rti_tri_if.sv
rtl/core/rti_res_if.sv
rtl/core/rti_geom.sv
rtl/core/rti_classify.sv
rtl/core/rti_div.sv
rtl/core/rti_trace.sv
rtl/core/ray_triangle_intersect.sv
bench/ray_triangle_intersect_test.sv
